### hdl/bgc_pkg.sv
package bgc_pkg;

    localparam int NumPinsDefault = 16;
    localparam int InPins = 16;

    localparam logic [2:0] EV_OFF      = 3'd0;
    localparam logic [2:0] EV_SINGLE   = 3'd1;
    localparam logic [2:0] EV_DOUBLE   = 3'd2;
    localparam logic [2:0] EV_LONG     = 3'd3;
    localparam logic [2:0] EV_RELEASED = 3'd4;

    localparam logic [2:0] GS_IDLE         = 3'd0;
    localparam logic [2:0] GS_PRESSING     = 3'd1;
    localparam logic [2:0] GS_LONG_HELD    = 3'd2;
    localparam logic [2:0] GS_WAIT_DOUBLE  = 3'd3;
    localparam logic [2:0] GS_DBL_WAIT_REL = 3'd4;
    localparam logic [2:0] GS_OFF_DELAY    = 3'd5;

    localparam logic [2:0] REG_DEBOUNCE    = 3'd0;
    localparam logic [2:0] REG_LONG_MIN    = 3'd1;
    localparam logic [2:0] REG_DOUBLE_MAX  = 3'd2;
    localparam logic [2:0] REG_OFF_DELAY   = 3'd3;
    localparam logic [2:0] REG_REL_OFF     = 3'd4;

    typedef struct packed {
        logic [15:0] pin_levels;
        logic [31:0] now_ms;
    } bgc_in_t;

    typedef struct packed {
        logic [3:0] pin_index;
        logic [2:0] event_res;
        logic       last_of_poll;
    } bgc_out_t;

    typedef struct packed {
        logic [2:0]  index;
        logic [15:0] data;
    } bgc_cfg_t;

endpackage

### hdl/button_gesture_classifier_top.sv
// The last event of a poll is loaded after the sequencer has visited every pin, one
// pin a cycle except while a pin's events are emitted or wait on out_stall. The next
// poll is taken only after the previous one is flushed; the sequencer visits every
// pin three times (debounce, edge, tick).
// Reset: asynchronous, active low; all pin state cleared, registers to defaults.
module button_gesture_classifier_top #(
    parameter int NUM_PINS = bgc_pkg::NumPinsDefault
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_stall,
    input  bgc_pkg::bgc_in_t  in_data,
    output logic              out_valid,
    input  logic              out_stall,
    output bgc_pkg::bgc_out_t out_data,
    input  logic              cfg_valid,
    output logic              cfg_ready,
    input  bgc_pkg::bgc_cfg_t cfg_data
);
    import bgc_pkg::*;

    localparam int PW = (NUM_PINS > 1) ? $clog2(NUM_PINS) : 1;

    typedef enum logic [2:0] {
        S_IDLE, S_DEB, S_EDGE, S_TICK, S_EMIT, S_FLUSH
    } state_t;

    state_t      state_reg;
    logic [PW-1:0] pin_reg;
    logic [15:0] levels_reg;
    logic [31:0] now_reg;
    logic [15:0] deb_reg, lmin_reg, dmax_reg, offd_reg, roff_reg;

    logic [NUM_PINS-1:0] cand_lvl_reg, stab_vld_reg, stab_lvl_reg, chg_reg;
    logic [NUM_PINS-1:0] eprev_vld_reg, eprev_lvl_reg, long_rep_reg;
    logic [2:0]  gs_reg   [NUM_PINS];
    logic [2:0]  last_reg [NUM_PINS];
    logic [31:0] since_reg [NUM_PINS];
    logic [31:0] pstart_reg [NUM_PINS];
    logic [31:0] wdl_reg [NUM_PINS];
    logic [31:0] odl_reg [NUM_PINS];

    // event queue: at most two per pin step (edge or tick)
    logic [2:0]  pend_ev_reg [2];
    logic [1:0]  pend_cnt_reg;
    logic [1:0]  pend_rd_reg;
    state_t      ret_reg;
    logic        hold_vld_reg;
    bgc_out_t    hold_reg;

    assign in_stall  = (state_reg != S_IDLE);
    assign cfg_ready = (state_reg == S_IDLE) && !out_valid;

    // shared subtractor: now minus a selected timestamp
    logic [31:0] sub_b, diff;
    logic        raw;
    always_comb
    begin
        case (state_reg)
            S_DEB:   sub_b = since_reg[pin_reg];
            default: sub_b = (gs_reg[pin_reg] == GS_WAIT_DOUBLE) ? wdl_reg[pin_reg] :
                             (gs_reg[pin_reg] == GS_OFF_DELAY) ? odl_reg[pin_reg] :
                             pstart_reg[pin_reg];
        endcase
        diff = now_reg - sub_b;
        raw  = (32'(pin_reg) < InPins) ? levels_reg[4'(pin_reg)] : 1'b0;
    end

    // per-pin gesture step: up to two events
    logic [2:0]  gs_n;
    logic [31:0] odl_n, wdl_n, ps_n;
    logic        lr_n;
    logic [2:0]  ev_a, ev_b;
    logic        va, vb;
    logic [2:0]  last_n;
    logic        e_a, e_b;
    logic [1:0]  n_ev;
    logic        lvl;

    always_comb
    begin
        gs_n  = gs_reg[pin_reg];
        odl_n = odl_reg[pin_reg];
        wdl_n = wdl_reg[pin_reg];
        ps_n  = pstart_reg[pin_reg];
        lr_n  = long_rep_reg[pin_reg];
        ev_a = EV_OFF; ev_b = EV_OFF; va = 1'b0; vb = 1'b0;
        lvl = stab_lvl_reg[pin_reg];
        if (state_reg == S_EDGE) begin
            case (gs_reg[pin_reg])
                GS_IDLE:
                    if (lvl) begin
                        if (lmin_reg == 16'd0 && dmax_reg == 16'd0) begin
                            ev_a = EV_SINGLE; va = 1'b1;
                            if (offd_reg == 16'd0) begin
                                ev_b = EV_OFF; vb = 1'b1; gs_n = GS_IDLE; odl_n = '0;
                            end else begin
                                odl_n = now_reg + 32'(offd_reg); gs_n = GS_OFF_DELAY;
                            end
                        end else begin
                            odl_n = '0; gs_n = GS_PRESSING; ps_n = now_reg; lr_n = 1'b0;
                        end
                    end
                GS_PRESSING, GS_LONG_HELD:
                    if (!lvl) begin
                        if (gs_reg[pin_reg] == GS_PRESSING && diff < 32'(lmin_reg)) begin
                            if (dmax_reg == 16'd0) begin
                                ev_a = EV_SINGLE; va = 1'b1;
                                if (offd_reg == 16'd0) begin
                                    ev_b = EV_OFF; vb = 1'b1; gs_n = GS_IDLE; odl_n = '0;
                                end else begin
                                    odl_n = now_reg + 32'(offd_reg); gs_n = GS_OFF_DELAY;
                                end
                            end else begin
                                wdl_n = now_reg + 32'(dmax_reg); gs_n = GS_WAIT_DOUBLE;
                            end
                        end else begin
                            ev_a = EV_RELEASED; va = 1'b1;
                            if (roff_reg == 16'd0) begin
                                ev_b = EV_OFF; vb = 1'b1; gs_n = GS_IDLE; odl_n = '0;
                            end else begin
                                odl_n = now_reg + 32'(roff_reg); gs_n = GS_OFF_DELAY;
                            end
                        end
                    end
                GS_WAIT_DOUBLE:
                    if (lvl) begin
                        ev_a = EV_DOUBLE; va = 1'b1; odl_n = '0; gs_n = GS_DBL_WAIT_REL;
                    end
                GS_DBL_WAIT_REL:
                    if (!lvl) begin
                        if (offd_reg == 16'd0) begin
                            ev_a = EV_OFF; va = 1'b1; gs_n = GS_IDLE; odl_n = '0;
                        end else begin
                            odl_n = now_reg + 32'(offd_reg); gs_n = GS_OFF_DELAY;
                        end
                    end
                GS_OFF_DELAY:
                    if (lvl) begin
                        odl_n = '0; gs_n = GS_PRESSING; ps_n = now_reg; lr_n = 1'b0;
                    end
                default: ;
            endcase
        end else begin
            case (gs_reg[pin_reg])
                GS_PRESSING:
                    if (!long_rep_reg[pin_reg] && diff >= 32'(lmin_reg)) begin
                        ev_a = EV_LONG; va = 1'b1; lr_n = 1'b1; gs_n = GS_LONG_HELD;
                    end
                GS_WAIT_DOUBLE:
                    if (!diff[31]) begin
                        ev_a = EV_SINGLE; va = 1'b1;
                        if (offd_reg == 16'd0) begin
                            ev_b = EV_OFF; vb = 1'b1; gs_n = GS_IDLE; odl_n = '0;
                        end else begin
                            odl_n = now_reg + 32'(offd_reg); gs_n = GS_OFF_DELAY;
                        end
                    end
                GS_OFF_DELAY:
                    if (!diff[31]) begin
                        ev_a = EV_OFF; va = 1'b1; odl_n = '0; gs_n = GS_IDLE;
                    end
                default: ;
            endcase
        end
        // duplicate suppression against last event sent
        last_n = last_reg[pin_reg];
        e_a = va && (ev_a != last_n);
        if (e_a) last_n = ev_a;
        e_b = vb && (ev_b != last_n);
        if (e_b) last_n = ev_b;
        n_ev = {1'b0, e_a} + {1'b0, e_b};
    end

    logic edge_go;
    assign edge_go = chg_reg[pin_reg] &&
                     (!eprev_vld_reg[pin_reg] || eprev_lvl_reg[pin_reg] != stab_lvl_reg[pin_reg]);

    logic pin_last;
    assign pin_last = (32'(pin_reg) == NUM_PINS - 1);

    // held event moves to the output this cycle
    logic out_load;
    assign out_load = (state_reg == S_EMIT || state_reg == S_FLUSH) && hold_vld_reg &&
                      (!out_valid || !out_stall);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg <= S_IDLE;
            pin_reg <= '0;
            deb_reg <= 16'd50; lmin_reg <= 16'd500; dmax_reg <= 16'd300;
            offd_reg <= '0; roff_reg <= '0;
            cand_lvl_reg <= '0; stab_vld_reg <= '0; stab_lvl_reg <= '0; chg_reg <= '0;
            eprev_vld_reg <= '0; eprev_lvl_reg <= '0; long_rep_reg <= '0;
            for (int i = 0; i < NUM_PINS; i++) begin
                gs_reg[i] <= GS_IDLE; last_reg[i] <= EV_OFF; since_reg[i] <= '0;
                pstart_reg[i] <= '0; wdl_reg[i] <= '0; odl_reg[i] <= '0;
            end
            pend_cnt_reg <= '0; pend_rd_reg <= '0; ret_reg <= S_IDLE;
            hold_vld_reg <= 1'b0; out_valid <= 1'b0;
        end else begin
            if (out_valid && !out_stall && !out_load) out_valid <= 1'b0;
            case (state_reg)
                S_IDLE:
                begin
                    if (cfg_valid && cfg_ready) begin
                        case (cfg_data.index)
                            REG_DEBOUNCE:   deb_reg  <= cfg_data.data;
                            REG_LONG_MIN:   lmin_reg <= cfg_data.data;
                            REG_DOUBLE_MAX: dmax_reg <= cfg_data.data;
                            REG_OFF_DELAY:  offd_reg <= cfg_data.data;
                            REG_REL_OFF:    roff_reg <= cfg_data.data;
                            default: ;
                        endcase
                    end
                    if (in_valid) begin
                        levels_reg <= in_data.pin_levels;
                        now_reg <= in_data.now_ms;
                        pin_reg <= '0;
                        hold_vld_reg <= 1'b0;
                        state_reg <= S_DEB;
                    end
                end
                S_DEB:
                begin
                    if (raw != cand_lvl_reg[pin_reg]) begin
                        cand_lvl_reg[pin_reg] <= raw;
                        since_reg[pin_reg] <= now_reg;
                        chg_reg[pin_reg] <= 1'b0;
                    end else if (diff >= 32'(deb_reg) &&
                                 (!stab_vld_reg[pin_reg] || stab_lvl_reg[pin_reg] != raw)) begin
                        stab_vld_reg[pin_reg] <= 1'b1;
                        stab_lvl_reg[pin_reg] <= raw;
                        chg_reg[pin_reg] <= 1'b1;
                    end else begin
                        chg_reg[pin_reg] <= 1'b0;
                    end
                    pin_reg <= pin_last ? '0 : pin_reg + 1'b1;
                    if (pin_last) state_reg <= S_EDGE;
                end
                S_EDGE, S_TICK:
                begin
                    if (state_reg == S_TICK || edge_go) begin
                        if (state_reg == S_EDGE) begin
                            eprev_vld_reg[pin_reg] <= 1'b1;
                            eprev_lvl_reg[pin_reg] <= stab_lvl_reg[pin_reg];
                        end
                        gs_reg[pin_reg] <= gs_n; odl_reg[pin_reg] <= odl_n;
                        wdl_reg[pin_reg] <= wdl_n; pstart_reg[pin_reg] <= ps_n;
                        long_rep_reg[pin_reg] <= lr_n; last_reg[pin_reg] <= last_n;
                    end
                    if ((state_reg == S_TICK || edge_go) && n_ev != 2'd0) begin
                        pend_ev_reg[0] <= e_a ? ev_a : ev_b;
                        pend_ev_reg[1] <= ev_b;
                        pend_cnt_reg <= n_ev;
                        pend_rd_reg <= '0;
                        ret_reg <= (pin_last && state_reg == S_TICK) ? S_FLUSH :
                                   pin_last ? S_TICK : state_reg;
                        state_reg <= S_EMIT;
                    end else if (pin_last) begin
                        state_reg <= (state_reg == S_EDGE) ? S_TICK : S_FLUSH;
                    end
                    pin_reg <= pin_last ? '0 : pin_reg + 1'b1;
                end
                S_EMIT:
                begin
                    // each new event pushes the held one out; last flagged at flush
                    if (!hold_vld_reg || !out_valid || !out_stall) begin
                        if (hold_vld_reg) begin
                            out_data <= hold_reg;
                            out_valid <= 1'b1;
                        end
                        hold_reg.pin_index <= 4'(pin_reg == '0 ? PW'(NUM_PINS - 1)
                                                               : pin_reg - 1'b1);
                        hold_reg.event_res <= pend_ev_reg[pend_rd_reg[0]];
                        hold_reg.last_of_poll <= 1'b0;
                        hold_vld_reg <= 1'b1;
                        pend_rd_reg <= pend_rd_reg + 1'b1;
                        if (pend_rd_reg + 1'b1 == pend_cnt_reg) state_reg <= ret_reg;
                    end
                end
                S_FLUSH:
                begin
                    if (!hold_vld_reg) begin
                        state_reg <= S_IDLE;
                    end else if (!out_valid || !out_stall) begin
                        out_data <= '{pin_index: hold_reg.pin_index,
                                      event_res: hold_reg.event_res,
                                      last_of_poll: 1'b1};
                        out_valid <= 1'b1;
                        hold_vld_reg <= 1'b0;
                        state_reg <= S_IDLE;
                    end
                end
                default: state_reg <= S_IDLE;
            endcase
        end
    end

`ifndef NO_ASSERTIONS
    a_no_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg != S_IDLE) |-> in_stall) else $error("input taken while busy");
    a_cfg_idle: assert property (@(posedge clk) disable iff (!rst_n)
        cfg_ready |-> (state_reg == S_IDLE)) else $error("config while busy");
    a_pend: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_EMIT) |-> (pend_cnt_reg != 2'd0)) else $error("empty emit");
`endif

endmodule
